// File: sv/mrc_pkg.sv
// Shared types, constants and the CRC byte update for the Modbus RTU response checker.
// No dependencies; imported by mrc_frame, modbus_rtu_response_checker and the bench files.
`timescale 1ns / 1ps

package mrc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] MIN_FRAME_BYTES = 8'd5;
	localparam logic [7:0] POS_MAX = 8'd255;
	localparam logic [7:0] POS_COUNT = 8'd2;
	localparam logic [7:0] POS_DATA = 8'd3;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_SHORT   = 2'd1,
		STATUS_CRC_BAD = 2'd2
	} frame_status_t;

	typedef enum logic {
		KIND_REGISTER = 1'b0,
		KIND_STATUS   = 1'b1
	} result_kind_t;

	typedef struct packed {
		result_kind_t  kind;
		logic [6:0]    index;
		logic [15:0]   value;
		frame_status_t status;
	} result_t;

	// Reflected CRC-16, one byte, LSB first.
	function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

endpackage

// File: sv/mrc_frame.sv
// Frame state of the response checker: CRC, two-byte delay line, position and byte count.
// Produces at most one result per accepted byte; depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_frame import mrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	output logic       res_valid,
	output result_t    res
);

	logic [15:0] crc_q;
	logic [7:0]  byte_one_q;
	logic [7:0]  byte_two_q;
	logic [7:0]  pos_q;
	logic [7:0]  count_q;
	logic [7:0]  high_q;

	logic [15:0] crc_next;
	logic [15:0] rx_crc;
	logic [7:0]  data_off;
	logic        emit_reg;

	always_comb begin
		crc_next = (pos_q >= POS_COUNT) ? crc_absorb(crc_q, byte_two_q) : crc_q;
		rx_crc = {rx_byte, byte_one_q};
		data_off = pos_q - POS_COUNT;
		// Low byte of a register lands on even positions from 4 on.
		emit_reg = (pos_q > POS_DATA) && !pos_q[0] && (data_off <= count_q);
	end

	always_comb begin
		res = '0;
		res_valid = 1'b0;
		if (frame_end) begin
			res_valid = 1'b1;
			res.kind = KIND_STATUS;
			if ({1'b0, pos_q} + 9'd1 < {1'b0, MIN_FRAME_BYTES}) res.status = STATUS_SHORT;
			else if (rx_crc != crc_next) res.status = STATUS_CRC_BAD;
			else res.status = STATUS_OK;
		end else if (emit_reg) begin
			res_valid = 1'b1;
			res.kind = KIND_REGISTER;
			res.index = data_off[7:1] - 7'd1;
			res.value = {high_q, rx_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			byte_one_q <= '0;
			byte_two_q <= '0;
			pos_q <= '0;
			count_q <= '0;
			high_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				// Return to the idle frame state.
				crc_q <= CRC_INIT;
				byte_one_q <= '0;
				byte_two_q <= '0;
				pos_q <= '0;
				count_q <= '0;
				high_q <= '0;
			end else begin
				crc_q <= crc_next;
				byte_two_q <= byte_one_q;
				byte_one_q <= rx_byte;
				if (pos_q == POS_COUNT) count_q <= rx_byte;
				if (pos_q >= POS_DATA && pos_q[0]) high_q <= rx_byte;
				if (pos_q != POS_MAX) pos_q <= pos_q + 8'd1;
			end
		end
	end

endmodule

// File: sv/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU read-holding-registers response checker.
// Instantiates mrc_frame and a two-entry result buffer; depends on mrc_pkg.
`timescale 1ns / 1ps

// Takes one response byte per clock, unless in_stall is high, and gives register
// values and a final frame status. The CRC byte update is an unrolled combinational
// step in mrc_frame. Each result is registered in an output register backed by a
// skid register, so the input keeps flowing while one result waits on a stalled
// consumer. Register results of a frame whose status is not ok must be dropped by
// the consumer.

module modbus_rtu_response_checker import mrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [6:0]  reg_index,
	output logic [15:0] reg_value,
	output logic [1:0]  frame_status
);

	logic    accept;
	logic    res_valid;
	result_t res;
	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;
	logic    push;

	assign in_stall = skid_valid_q;
	assign accept = in_valid && !skid_valid_q;
	assign pop = main_valid_q && !out_stall;
	assign push = accept && res_valid;

	mrc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (push) begin
				if (!main_valid_q || pop) main_valid_q <= 1'b1;
				else skid_valid_q <= 1'b1;
			end else if (pop) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) main_q <= skid_q;
		else if (push && (!main_valid_q || pop)) main_q <= res;
		if (push && main_valid_q && !pop) skid_q <= res;
	end

	assign out_valid = main_valid_q;
	assign result_kind = main_q.kind;
	assign reg_index = main_q.index;
	assign reg_value = main_q.value;
	assign frame_status = main_q.status;

endmodule

// File: tb/sv/mrc_response_tracker.sv
// Watches both channels of the Modbus RTU response checker and predicts its results.
// Compares each accepted result with the oldest prediction; depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_response_tracker import mrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        result_kind,
	input  logic [6:0]  reg_index,
	input  logic [15:0] reg_value,
	input  logic [1:0]  frame_status,
	output int          mismatch_count,
	output int          due_count
);

	logic [15:0] crc_acc;
	logic [7:0]  newest_byte;
	logic [7:0]  prior_byte;
	logic [7:0]  byte_pos;
	logic [7:0]  count_field;
	logic [7:0]  high_half;
	result_t     due_results[$];

	// Bit-serial form of the reflected CRC-16 byte update.
	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			r = (r[0] ^ data[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic clear_frame();
		crc_acc = CRC_INIT;
		newest_byte = 8'h00;
		prior_byte = 8'h00;
		byte_pos = 8'h00;
		count_field = 8'h00;
		high_half = 8'h00;
	endtask

	task automatic decode_response_byte(input logic [7:0] b, input logic last);
		result_t r;
		logic [7:0] p;
		p = byte_pos;
		// CRC trails the newest byte by two, so the trailing CRC bytes never enter it
		if (p >= POS_COUNT) crc_acc = crc16_step(crc_acc, prior_byte);
		prior_byte = newest_byte;
		newest_byte = b;
		if (p == POS_COUNT) count_field = b;
		if (last) begin
			r.kind = KIND_STATUS;
			r.index = 7'd0;
			r.value = 16'h0000;
			if (int'(p) + 1 < int'(MIN_FRAME_BYTES)) begin
				r.status = STATUS_SHORT;
			end else if ({newest_byte, prior_byte} != crc_acc) begin
				r.status = STATUS_CRC_BAD;
			end else begin
				r.status = STATUS_OK;
			end
			due_results = {due_results, r};
			clear_frame();
		end else begin
			// odd positions carry the high byte, even ones complete a register
			if (p >= POS_DATA) begin
				if (p[0]) begin
					high_half = b;
				end else if (int'(p) - 2 <= int'(count_field)) begin
					r.kind = KIND_REGISTER;
					r.index = 7'((p - 8'd4) >> 1);
					r.value = {high_half, b};
					r.status = STATUS_OK;
					due_results = {due_results, r};
				end
			end
			if (byte_pos != POS_MAX) byte_pos = byte_pos + 8'd1;
		end
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic check_result();
		result_t want;
		if (due_results.size() == 0) begin
			mismatch_count++;
			$display("%0t: result expected none, got kind %0d index %0d value %0h status %0d",
				$time, result_kind, reg_index, reg_value, frame_status);
		end else begin
			want = due_results.pop_front();
			compare_field("result_kind", 16'(want.kind), 16'(result_kind));
			compare_field("reg_index", 16'(want.index), 16'(reg_index));
			compare_field("reg_value", want.value, reg_value);
			compare_field("frame_status", 16'(want.status), 16'(frame_status));
		end
	endtask

	// Results leave a register stage, so check before adding this edge's request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			due_results.delete();
		end else begin
			if (out_valid && !out_stall) check_result();
			if (in_valid && !in_stall) decode_response_byte(rx_byte, frame_end);
		end
		due_count = due_results.size();
	end

endmodule

// File: tb/sv/modbus_rtu_response_checker_test.sv
// Top of the response checker bench: clock, reset, response frames and the verdict.
// Depends on mrc_pkg, modbus_rtu_response_checker and mrc_response_tracker.
`timescale 1ns / 1ps

module modbus_rtu_response_checker_test import mrc_pkg::*;;

	localparam int RANDOM_ITEMS = 700;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        result_kind;
	logic [6:0]  reg_index;
	logic [15:0] reg_value;
	logic [1:0]  frame_status;
	int          mismatch_count;
	int          due_count;

	int          send_idle_pct = 12;
	int          recv_stall_pct = 54;
	int          sent_items = 0;
	int          idle_cycles = 0;
	logic [7:0]  frame_q[$];

	modbus_rtu_response_checker i_dut (.*);

	mrc_response_tracker i_tracker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Enter and leave at a rising edge; stall is checked mid-cycle to stay clear of races.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_end <= last;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		sent_items++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
		frame_q.delete();
	endtask

	task automatic add_byte(input logic [7:0] b);
		frame_q = {frame_q, b};
	endtask

	task automatic start_response(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] count);
		add_byte(addr);
		add_byte(func);
		add_byte(count);
	endtask

	// Append the frame CRC, low byte first; flip bits to spoil it on purpose.
	task automatic append_crc(input logic [15:0] flip);
		logic [15:0] acc;
		acc = CRC_INIT;
		foreach (frame_q[i]) begin
			for (int k = 0; k < 8; k++)
				acc = (acc[0] ^ frame_q[i][k]) ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		end
		acc = acc ^ flip;
		add_byte(acc[7:0]);
		add_byte(acc[15:8]);
	endtask

	task automatic random_frame(input bit force_long);
		int sel;
		int count;
		int data_len;
		int pick;
		sel = force_long ? 0 : $urandom_range(0, 99);
		if (sel >= 82) begin
			// too short, or plain noise of up to 40 bytes
			data_len = (sel < 90) ? $urandom_range(1, 4) : $urandom_range(1, 40);
			repeat (data_len) add_byte(8'($urandom));
		end else begin
			if (force_long) count = 255;
			else if ($urandom_range(0, 39) == 0) count = $urandom_range(128, 254);
			else count = 2 * $urandom_range(0, 12);
			data_len = count;
			// byte count that disagrees with the data actually sent
			if (sel >= 60 && sel < 72) begin
				count = $urandom_range(0, 255);
				data_len = $urandom_range(0, 30);
			end
			start_response(8'($urandom),
				($urandom_range(0, 7) == 0) ? 8'($urandom) : FUNC_READ_HOLDING, 8'(count));
			repeat (data_len) add_byte(8'($urandom));
			append_crc(16'h0000);
			// single bit error anywhere in the frame
			if (sel >= 72) begin
				pick = $urandom_range(0, frame_q.size() - 1);
				frame_q[pick] = frame_q[pick] ^ 8'(1 << $urandom_range(0, 7));
			end
		end
		send_frame();
	endtask

	initial begin
		int frame_no;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// shortest valid response, no registers
		start_response(8'h01, FUNC_READ_HOLDING, 8'h00);
		append_crc(16'h0000);
		send_frame();
		// single byte frame
		add_byte(8'hFF);
		send_frame();
		// one byte under the minimum
		start_response(8'h00, 8'h00, 8'h00);
		add_byte(8'h00);
		send_frame();
		// extreme register values
		start_response(8'hFF, FUNC_READ_HOLDING, 8'h04);
		add_byte(8'h00);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'hFF);
		append_crc(16'h0000);
		send_frame();
		// CRC mismatch
		start_response(8'h11, FUNC_READ_HOLDING, 8'h00);
		append_crc(16'h8000);
		send_frame();

		sent_items = 0;
		frame_no = 0;
		while (sent_items < RANDOM_ITEMS) begin
			if (sent_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 12;
				recv_stall_pct = 54;
			end else if (sent_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 54;
				recv_stall_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			// one full-size response drives the position counter into saturation
			random_frame(frame_no == 3);
			frame_no++;
		end
		in_valid <= 1'b0;

		while (due_count != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && due_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
